/* hdl/ucbsel_pkg.sv */
// Shared constants, types and codes of the UCB1 arm selector.
`default_nettype none

package ucbsel_pkg;

  localparam int NumArms   = 8;
  localparam int FracBits  = 16;
  localparam int ArmW      = $clog2(NumArms);
  localparam int NW        = $clog2(NumArms + 1);
  localparam int CfgW      = 4;
  localparam int PlayW     = 20;
  localparam int SumW      = 40;
  localparam int TotW      = 24;
  localparam int XW        = 32;
  localparam int DivW      = SumW + FracBits;
  localparam int LgW       = $clog2(TotW) + FracBits;
  localparam int ArgW      = LgW + 1;
  localparam int SqrtPairs = (ArgW + FracBits + 1) / 2;
  localparam int SqrtInW   = 2 * SqrtPairs;
  localparam int RootW     = SqrtPairs;
  localparam int CmpW      = (PlayW + 1 > RootW + 2) ? PlayW + 1 : RootW + 2;
  localparam int UcbW      = 32 + FracBits;
  localparam int CntW      = $clog2(DivW + 1);

  localparam logic [31:0]     Ln2Q32    = 32'hB17217F7;
  localparam logic [CfgW-1:0] ArmsReset = 4'd6;

  localparam logic       KindRecord   = 1'b1;
  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusBadArm = 2'd1;
  localparam logic [1:0] StatusSat    = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [2:0]  arm;
    logic [19:0] reward;
  } in_req_t;

  typedef struct packed {
    logic [2:0] next_arm;
    logic       exploring;
    logic [2:0] best_arm;
    logic       best_valid;
    logic [1:0] status;
  } out_rsp_t;

  typedef enum logic [1:0] {OpDiv, OpSqrt, OpLog} alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_cmd_t;

  typedef enum logic [2:0] {AluIdle, AluDiv, AluSqrt, AluNorm, AluSqr, AluLnMul} alu_st_e;

  typedef enum logic [3:0] {
    SeqIdle, SeqUpdate, SeqScan, SeqLog, SeqLogWait,
    SeqArm, SeqMeanWait, SeqArgWait, SeqSqrtWait, SeqDone
  } seq_e;

endpackage

`default_nettype wire

/* hdl/ucb1_arm_selector_top.sv */
// Top level of the UCB1 arm selector: sequencer, output register and assertions.
// While an arm is unplayed, each played arm in use gets one division for its mean.
// Once all arms are played, the log is taken first and each arm then takes an issue state,
// two divisions (mean and argument) and a root.
// One request is in work at a time; the next is accepted while the result waits to be taken.
// Reset clears all play counts, reward sums and the total, and sets arms in use to six.
`default_nettype none

module ucb1_arm_selector_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ucbsel_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ucbsel_pkg::in_req_t         in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ucbsel_pkg::out_rsp_t        out_rsp_o
);
  import ucbsel_pkg::*;

  seq_e            seq_q, seq_d;
  logic [CfgW-1:0] cfg_q;
  in_req_t         req_q, req_d;
  logic [1:0]      status_q, status_d;
  logic            explore_q, explore_d;
  logic [ArmW-1:0] next_q, next_d;
  logic [NW-1:0]   j_q, j_d;
  logic [ArgW-1:0] two_ln_q, two_ln_d;
  logic [DivW-1:0] mean_q, mean_d;
  logic [ArmW-1:0] best_q, best_d;
  logic [DivW-1:0] best_top_q, best_top_d;
  logic            best_valid_q, best_valid_d;
  logic [UcbW-1:0] ucb_top_q, ucb_top_d;
  logic            found_q, found_d;
  logic            out_valid_q, out_valid_d;
  out_rsp_t        out_q, out_d;

  logic [NumArms-1:0][PlayW-1:0] play;
  logic [NumArms-1:0][SumW-1:0]  sum;
  logic [TotW-1:0]               total;
  logic [1:0]                    stats_status;

  alu_cmd_t         cmd;
  logic [DivW-1:0]  opa;
  logic [PlayW-1:0] opb;
  logic             alu_done;
  logic [DivW-1:0]  alu_res;

  logic [NW-1:0]    n;
  logic             expl;
  logic [ArmW-1:0]  first;
  logic [ArmW-1:0]  ja;
  logic [PlayW-1:0] play_cur;
  logic [SumW-1:0]  sum_cur;
  logic [DivW:0]    ucb_sum;
  logic [UcbW-1:0]  ucb;

  ucbsel_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (seq_q == SeqUpdate),
    .req_i   (req_q),
    .n_i     (n),
    .play_o  (play),
    .sum_o   (sum),
    .total_o (total),
    .status_o(stats_status)
  );

  ucbsel_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .opa_i (opa),
    .opb_i (opb),
    .done_o(alu_done),
    .res_o (alu_res)
  );

  always_comb begin
    if (cfg_q == '0) begin
      n = NW'(1);
    end else if (cfg_q > CfgW'(NumArms)) begin
      n = NW'(NumArms);
    end else begin
      n = NW'(cfg_q);
    end
    expl  = 1'b0;
    first = '0;
    for (int i = NumArms - 1; i >= 0; i--) begin
      if ((i < int'(n)) && (play[i] == '0)) begin
        expl  = 1'b1;
        first = ArmW'(i);
      end
    end
    ja       = j_q[ArmW-1:0];
    play_cur = play[ja];
    sum_cur  = sum[ja];
    ucb_sum  = (DivW+1)'(mean_q) + (DivW+1)'(alu_res[RootW-1:0]);
    ucb      = (|ucb_sum[DivW:UcbW]) ? '1 : ucb_sum[UcbW-1:0];
  end

  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SeqIdle:     if (in_valid_i) seq_d = SeqUpdate;
      SeqUpdate:   seq_d = SeqScan;
      SeqScan:     seq_d = expl ? SeqArm : SeqLog;
      SeqLog:      seq_d = SeqLogWait;
      SeqLogWait:  if (alu_done) seq_d = SeqArm;
      SeqArm: begin
        if (j_q == n) begin
          seq_d = SeqDone;
        end else if (play_cur != '0) begin
          seq_d = SeqMeanWait;
        end
      end
      SeqMeanWait: if (alu_done) seq_d = explore_q ? SeqArm : SeqArgWait;
      SeqArgWait:  if (alu_done) seq_d = SeqSqrtWait;
      SeqSqrtWait: if (alu_done) seq_d = SeqArm;
      SeqDone:     if (!out_valid_q || out_ready_i) seq_d = SeqIdle;
      default:     seq_d = SeqIdle;
    endcase
  end

  always_comb begin
    cmd.start    = 1'b0;
    cmd.op       = OpDiv;
    opa          = {sum_cur, {FracBits{1'b0}}};
    opb          = play_cur;
    req_d        = req_q;
    status_d     = status_q;
    explore_d    = explore_q;
    next_d       = next_q;
    j_d          = j_q;
    two_ln_d     = two_ln_q;
    mean_d       = mean_q;
    best_d       = best_q;
    best_top_d   = best_top_q;
    best_valid_d = best_valid_q;
    ucb_top_d    = ucb_top_q;
    found_d      = found_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    case (seq_q)
      SeqIdle: begin
        if (in_valid_i) req_d = in_req_i;
      end
      SeqUpdate: status_d = stats_status;
      SeqScan: begin
        explore_d    = expl;
        next_d       = expl ? first : '0;
        j_d          = '0;
        best_d       = '0;
        best_top_d   = '0;
        best_valid_d = 1'b0;
        found_d      = 1'b0;
      end
      SeqLog: begin
        cmd.start = 1'b1;
        cmd.op    = OpLog;
        opa       = DivW'(total);
      end
      SeqLogWait: begin
        if (alu_done) two_ln_d = {alu_res[LgW-1:0], 1'b0};
      end
      SeqArm: begin
        if (j_q != n) begin
          if (play_cur == '0) begin
            j_d = j_q + NW'(1);
          end else begin
            cmd.start = 1'b1;
            cmd.op    = OpDiv;
          end
        end
      end
      SeqMeanWait: begin
        if (alu_done) begin
          mean_d = alu_res;
          if (!best_valid_q || (alu_res > best_top_q)) begin
            best_top_d   = alu_res;
            best_d       = ja;
            best_valid_d = 1'b1;
          end
          if (explore_q) begin
            j_d = j_q + NW'(1);
          end else begin
            cmd.start = 1'b1;
            cmd.op    = OpDiv;
            opa       = DivW'(two_ln_q);
          end
        end
      end
      SeqArgWait: begin
        if (alu_done) begin
          cmd.start = 1'b1;
          cmd.op    = OpSqrt;
          opa       = DivW'(SqrtInW'({alu_res[ArgW-1:0], {FracBits{1'b0}}}));
        end
      end
      SeqSqrtWait: begin
        if (alu_done) begin
          if (!found_q || (ucb > ucb_top_q)) begin
            ucb_top_d = ucb;
            next_d    = ja;
            found_d   = 1'b1;
          end
          j_d = j_q + NW'(1);
        end
      end
      SeqDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.next_arm       = 3'(next_q);
          out_d.exploring      = explore_q;
          out_d.best_arm       = 3'(best_q);
          out_d.best_valid     = best_valid_q;
          out_d.status         = status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SeqIdle;
      cfg_q       <= ArmsReset;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    status_q     <= status_d;
    explore_q    <= explore_d;
    next_q       <= next_d;
    j_q          <= j_d;
    two_ln_q     <= two_ln_d;
    mean_q       <= mean_d;
    best_q       <= best_d;
    best_top_q   <= best_top_d;
    best_valid_q <= best_valid_d;
    ucb_top_q    <= ucb_top_d;
    found_q      <= found_d;
    out_q        <= out_d;
  end

  assign in_ready_o  = (seq_q == SeqIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (seq_q == SeqLogWait || seq_q == SeqMeanWait ||
                  seq_q == SeqArgWait || seq_q == SeqSqrtWait))
    else $error("Arithmetic unit finished outside a wait state.");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(seq_q) == SeqDone)
    else $error("Result presented without finishing a request.");

  a_exploit_has_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rsp_o.exploring) |-> out_rsp_o.best_valid)
    else $error("All arms played but no best arm reported.");

endmodule

`default_nettype wire

/* hdl/ucbsel_alu.sv */
// Shared iterative unit: restoring division, square root and natural log.
`default_nettype none

module ucbsel_alu (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ucbsel_pkg::alu_cmd_t         cmd_i,
  input  logic [ucbsel_pkg::DivW-1:0]  opa_i,
  input  logic [ucbsel_pkg::PlayW-1:0] opb_i,
  output logic                         done_o,
  output logic [ucbsel_pkg::DivW-1:0]  res_o
);
  import ucbsel_pkg::*;

  alu_st_e          st_q, st_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [CmpW-1:0]  acc_q, acc_d;
  logic [DivW-1:0]  sh_q, sh_d;
  logic [RootW-1:0] root_q, root_d;
  logic [PlayW-1:0] dvs_q, dvs_d;
  logic [XW-1:0]    x_q, x_d;
  logic [LgW-1:0]   lg_q, lg_d;
  logic [DivW-1:0]  res_q, res_d;

  logic [CmpW-1:0]    cmp_a, cmp_b, diff;
  logic               ge;
  logic [2*XW-1:0]    sq;
  logic [XW:0]        y;
  logic [LgW+31:0]    lnp;

  always_comb begin
    if (st_q == AluSqrt) begin
      cmp_a = {acc_q[CmpW-3:0], sh_q[DivW-1 -: 2]};
      cmp_b = CmpW'({root_q, 2'b01});
    end else begin
      cmp_a = {acc_q[CmpW-2:0], sh_q[DivW-1]};
      cmp_b = CmpW'(dvs_q);
    end
    ge   = (cmp_a >= cmp_b);
    diff = cmp_a - cmp_b;
    sq   = x_q * x_q;
    y    = sq[2*XW-1:XW-1];
    lnp  = lg_q * Ln2Q32;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      AluIdle: begin
        if (cmd_i.start) begin
          case (cmd_i.op)
            OpDiv:   st_d = AluDiv;
            OpSqrt:  st_d = AluSqrt;
            OpLog:   st_d = (opa_i[TotW-1:0] == '0) ? AluIdle : AluNorm;
            default: st_d = AluIdle;
          endcase
        end
      end
      AluDiv, AluSqrt: begin
        if (cnt_q == CntW'(1)) st_d = AluIdle;
      end
      AluNorm: begin
        if (x_q[XW-1]) st_d = AluSqr;
      end
      AluSqr: begin
        if (cnt_q == CntW'(1)) st_d = AluLnMul;
      end
      AluLnMul: st_d = AluIdle;
      default:  st_d = AluIdle;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    sh_d   = sh_q;
    root_d = root_q;
    dvs_d  = dvs_q;
    x_d    = x_q;
    lg_d   = lg_q;
    res_d  = res_q;
    case (st_q)
      AluIdle: begin
        if (cmd_i.start) begin
          case (cmd_i.op)
            OpDiv: begin
              acc_d = '0;
              sh_d  = opa_i;
              dvs_d = opb_i;
              cnt_d = CntW'(DivW);
            end
            OpSqrt: begin
              acc_d  = '0;
              root_d = '0;
              sh_d   = opa_i << (DivW - SqrtInW);
              cnt_d  = CntW'(SqrtPairs);
            end
            OpLog: begin
              if (opa_i[TotW-1:0] == '0) begin
                res_d  = '0;
                done_d = 1'b1;
              end else begin
                x_d  = XW'(opa_i[TotW-1:0]);
                lg_d = LgW'(XW - 1);
              end
            end
            default: ;
          endcase
        end
      end
      AluDiv: begin
        acc_d = ge ? diff : cmp_a;
        sh_d  = {sh_q[DivW-2:0], ge};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          res_d  = {sh_q[DivW-2:0], ge};
          done_d = 1'b1;
        end
      end
      AluSqrt: begin
        acc_d  = ge ? diff : cmp_a;
        root_d = {root_q[RootW-2:0], ge};
        sh_d   = sh_q << 2;
        cnt_d  = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          res_d  = DivW'({root_q[RootW-2:0], ge});
          done_d = 1'b1;
        end
      end
      AluNorm: begin
        if (x_q[XW-1]) begin
          cnt_d = CntW'(FracBits);
        end else begin
          x_d  = x_q << 1;
          lg_d = lg_q - LgW'(1);
        end
      end
      AluSqr: begin
        lg_d  = {lg_q[LgW-2:0], y[XW]};
        x_d   = y[XW] ? y[XW:1] : y[XW-1:0];
        cnt_d = cnt_q - CntW'(1);
      end
      AluLnMul: begin
        res_d  = DivW'(lnp[LgW+31:32]);
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= AluIdle;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    sh_q   <= sh_d;
    root_q <= root_d;
    dvs_q  <= dvs_d;
    x_q    <= x_d;
    lg_q   <= lg_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

/* hdl/ucbsel_stats.sv */
// Per-arm play counts and reward sums with the total play count, all saturating.
`default_nettype none

module ucbsel_stats (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              upd_i,
  input  ucbsel_pkg::in_req_t                               req_i,
  input  logic [ucbsel_pkg::NW-1:0]                         n_i,
  output logic [ucbsel_pkg::NumArms-1:0][ucbsel_pkg::PlayW-1:0] play_o,
  output logic [ucbsel_pkg::NumArms-1:0][ucbsel_pkg::SumW-1:0]  sum_o,
  output logic [ucbsel_pkg::TotW-1:0]                       total_o,
  output logic [1:0]                                        status_o
);
  import ucbsel_pkg::*;

  logic [NumArms-1:0][PlayW-1:0] play_q, play_d;
  logic [NumArms-1:0][SumW-1:0]  sum_q, sum_d;
  logic [TotW-1:0]               total_q, total_d;

  logic [ArmW-1:0] idx;
  logic            bad, play_sat, sum_sat, tot_sat, rec;
  logic [SumW:0]   sum_inc;

  always_comb begin
    idx      = ArmW'(req_i.arm);
    bad      = ({{NW{1'b0}}, req_i.arm} >= {3'b000, n_i});
    play_sat = (play_q[idx] == '1);
    sum_inc  = {1'b0, sum_q[idx]} + (SumW+1)'(req_i.reward);
    sum_sat  = sum_inc[SumW];
    tot_sat  = (total_q == '1);
    rec      = upd_i && (req_i.kind == KindRecord) && !bad;

    if (req_i.kind != KindRecord) begin
      status_o = StatusOk;
    end else if (bad) begin
      status_o = StatusBadArm;
    end else if (play_sat || sum_sat || tot_sat) begin
      status_o = StatusSat;
    end else begin
      status_o = StatusOk;
    end

    play_d  = play_q;
    sum_d   = sum_q;
    total_d = total_q;
    if (rec) begin
      play_d[idx] = play_sat ? play_q[idx] : play_q[idx] + PlayW'(1);
      sum_d[idx]  = sum_sat ? '1 : sum_inc[SumW-1:0];
      total_d     = tot_sat ? total_q : total_q + TotW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_q  <= '0;
      sum_q   <= '0;
      total_q <= '0;
    end else begin
      play_q  <= play_d;
      sum_q   <= sum_d;
      total_q <= total_d;
    end
  end

  assign play_o  = play_q;
  assign sum_o   = sum_q;
  assign total_o = total_q;

endmodule

`default_nettype wire
